// File: design/utf8v_pkg.sv
package utf8v_pkg;

  // Rule codes for the byte that follows a lead byte
  localparam logic [2:0] RULE_NONE = 3'd0;  // 80..BF
  localparam logic [2:0] RULE_E0   = 3'd1;  // A0..BF
  localparam logic [2:0] RULE_ED   = 3'd2;  // 80..9F
  localparam logic [2:0] RULE_F0   = 3'd3;  // 90..BF
  localparam logic [2:0] RULE_F4   = 3'd4;  // 80..8F

  // Byte boundaries
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD_LIMIT  = 8'hF5;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] CONT_E0_MIN = 8'hA0;
  localparam logic [7:0] CONT_ED_MAX = 8'h9F;
  localparam logic [7:0] CONT_F0_MIN = 8'h90;
  localparam logic [7:0] CONT_F4_MAX = 8'h8F;

  // Per-string decoder state
  typedef struct packed {
    logic [1:0] pend;     // continuation bytes still owed
    logic [2:0] rule;     // range rule for the next continuation byte
    logic       failed;   // sticky error
  } utf8v_state_t;

  localparam utf8v_state_t STATE_CLEAR = '{pend: 2'd0, rule: RULE_NONE, failed: 1'b0};

endpackage

// File: design/utf8v_step.sv
module utf8v_step (
  input  utf8v_pkg::utf8v_state_t state_cur,
  input  logic [7:0]              data_byte,
  input  logic                    has_byte,
  output utf8v_pkg::utf8v_state_t state_nxt,
  output logic                    verdict
);
  import utf8v_pkg::*;

  logic [7:0] lo;
  logic [7:0] hi;

  // Allowed window for a continuation byte
  always_comb begin
    lo = CONT_MIN;
    hi = CONT_MAX;
    unique case (state_cur.rule)
      RULE_E0: lo = CONT_E0_MIN;
      RULE_ED: hi = CONT_ED_MAX;
      RULE_F0: lo = CONT_F0_MIN;
      RULE_F4: hi = CONT_F4_MAX;
      default: ;
    endcase
  end

  // One word of state update
  always_comb begin
    state_nxt = state_cur;
    if (has_byte && !state_cur.failed) begin
      if (state_cur.pend == 2'd0) begin
        // lead byte
        priority if (data_byte < ASCII_LIMIT) begin
          state_nxt = state_cur;
        end else if (data_byte < LEAD2_MIN) begin
          state_nxt.failed = 1'b1;
        end else if (data_byte < LEAD3_MIN) begin
          state_nxt.pend = 2'd1;
          state_nxt.rule = RULE_NONE;
        end else if (data_byte < LEAD4_MIN) begin
          state_nxt.pend = 2'd2;
          state_nxt.rule = (data_byte == LEAD_E0) ? RULE_E0 :
                           (data_byte == LEAD_ED) ? RULE_ED : RULE_NONE;
        end else if (data_byte < LEAD_LIMIT) begin
          state_nxt.pend = 2'd3;
          state_nxt.rule = (data_byte == LEAD_F0) ? RULE_F0 :
                           (data_byte == LEAD_F4) ? RULE_F4 : RULE_NONE;
        end else begin
          state_nxt.failed = 1'b1;
        end
      end else begin
        // continuation byte
        if (data_byte < lo || data_byte > hi) begin
          state_nxt.failed = 1'b1;
        end else begin
          state_nxt.rule = RULE_NONE;
          state_nxt.pend = state_cur.pend - 2'd1;
        end
      end
    end
  end

  assign verdict = !state_nxt.failed && (state_nxt.pend == 2'd0);

endmodule

// File: design/utf8_stream_validator.sv
// UTF-8 stream validator. Takes one byte word per cycle on the in_ channel; a
// word with in_end_of_string set closes the string (its byte, if in_has_byte is
// set, counts first; a bare end marker is allowed, so an empty string is valid)
// and one verdict word follows on out_string_valid. Rejects stray continuation
// bytes, lead bytes C0, C1 and F5..FF, overlong forms, surrogates, code points
// above 10FFFF and sequences cut short. An end word passes through the input
// register and then the verdict register; throughput is one word per cycle, set
// by the combinational state update between the input register and the state
// register. Only an uncollected verdict stalls the input side.
module utf8_stream_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_has_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_string_valid
);
  import utf8v_pkg::*;

  logic         in_v_r;
  logic [7:0]   byte_r;
  logic         has_r;
  logic         end_r;
  utf8v_state_t state_r;
  utf8v_state_t state_nxt;
  logic         verdict;
  logic         out_v_r;
  logic         out_sv_r;
  logic         out_free;
  logic         adv;

  // Handshake: the stage holding a word moves on unless it ends a string and
  // the verdict register is still full
  assign out_free = !out_v_r || out_ready;
  assign adv      = in_v_r && (!end_r || out_free);
  assign in_ready = !in_v_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      has_r  <= in_has_byte;
      end_r  <= in_end_of_string;
    end
  end

  utf8v_step u_step (
    .state_cur (state_r),
    .data_byte (byte_r),
    .has_byte  (has_r),
    .state_nxt (state_nxt),
    .verdict   (verdict)
  );

  // Decoder state; cleared after each verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (adv) begin
      state_r <= end_r ? STATE_CLEAR : state_nxt;
    end
  end

  // Verdict register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && end_r) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && end_r) begin
      out_sv_r <= verdict;
    end
  end

  assign out_valid        = out_v_r;
  assign out_string_valid = out_sv_r;

endmodule

// File: design/utf8v_checker.sv
module utf8v_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_data_byte,
  input logic       in_has_byte,
  input logic       in_end_of_string,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_string_valid
);

  // A held verdict stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_string_valid))
    else $error("verdict dropped or changed while stalled");

  // With the verdict register empty the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty verdict register");

  // A fresh verdict follows an accepted end word
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_end_of_string, 2))
    else $error("verdict without matching end word");

  // A closing byte of F5..FF can never end a valid string
  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && $past(in_has_byte && (in_data_byte >= 8'hF5), 2)
    |-> !out_string_valid)
    else $error("string ending in invalid byte reported valid");

endmodule

bind utf8_stream_validator utf8v_checker u_chk (.*);
